>>> src/stxrx_pkg.sv
// stxrx_pkg: shared types and constants of the frame receiver
`default_nettype none

package stxrx_pkg;

  // delimiters and limits of the frame format
  localparam logic [7:0] START_DELIM   = 8'h02;
  localparam logic [7:0] END_DELIM     = 8'h03;
  localparam logic [7:0] MIN_FRAME_LEN = 8'd4;
  localparam int unsigned NUM_BANKS    = 2;

  // input operation codes
  localparam logic OP_BYTE   = 1'b0;
  localparam logic OP_RESYNC = 1'b1;

  // receive phase of the front part
  typedef enum logic [1:0] {
    PH_HUNT  = 2'd0,
    PH_SYNC  = 2'd1,
    PH_FRAME = 2'd2
  } phase_e;

  // drain sequencer of the back part
  typedef enum logic [1:0] {
    DR_IDLE = 2'd0,
    DR_READ = 2'd1,
    DR_WAIT = 2'd2,
    DR_OUT  = 2'd3
  } drain_e;

  // accepted frame waiting to be drained
  typedef struct packed {
    logic       bank;
    logic [7:0] addr;
    logic [7:0] plen;
  } desc_t;

  // frame store write request
  typedef struct packed {
    logic       en;
    logic       bank;
    logic [7:0] idx;
    logic [7:0] data;
  } wr_req_t;

  // bank release from the back part
  typedef struct packed {
    logic en;
    logic bank;
  } done_t;

endpackage

`default_nettype wire

>>> src/stxrx_front.sv
// stxrx_front: delimiter hunt, length check and frame store writes
`default_nettype none

module stxrx_front import stxrx_pkg::*; #(
  parameter int unsigned MAX_FRAME_LEN = 255
) (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    in_valid_i,
  output logic         in_stall_o,
  input  wire logic    op_i,
  input  wire logic [7:0] rx_byte_i,
  output wr_req_t      wr_o,
  output logic         push_o,
  output desc_t        desc_o,
  input  wire done_t   done_i
);

  phase_e          phase_q, phase_d;
  logic [7:0]      count_q, count_d;
  logic [7:0]      len_q, len_d;
  logic [7:0]      addr_q, addr_d;
  logic            bank_q, bank_d;
  logic [NUM_BANKS-1:0] busy_q, busy_d;
  logic            accept;

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HUNT;
      count_q <= '0;
      len_q   <= '0;
      addr_q  <= '0;
      bank_q  <= 1'b0;
      busy_q  <= '0;
    end else begin
      phase_q <= phase_d;
      count_q <= count_d;
      len_q   <= len_d;
      addr_q  <= addr_d;
      bank_q  <= bank_d;
      busy_q  <= busy_d;
    end
  end

  // hold off frame bytes while the write bank is still being drained
  assign in_stall_o = (phase_q == PH_FRAME) && busy_q[bank_q];
  assign accept     = in_valid_i && !in_stall_o;

  assign desc_o.bank = bank_q;
  assign desc_o.addr = addr_q;
  assign desc_o.plen = len_q - MIN_FRAME_LEN;

  // next state and store writes
  always_comb begin
    phase_d    = phase_q;
    count_d    = count_q;
    len_d      = len_q;
    addr_d     = addr_q;
    bank_d     = bank_q;
    push_o     = 1'b0;
    wr_o.en    = 1'b0;
    wr_o.bank  = bank_q;
    wr_o.idx   = count_q;
    wr_o.data  = rx_byte_i;

    if (accept) begin
      if (op_i == OP_RESYNC) begin
        phase_d = PH_HUNT;
      end else begin
        case (phase_q)
          PH_SYNC: begin
            if (rx_byte_i == START_DELIM) begin
              phase_d = PH_FRAME;
              count_d = '0;
            end else begin
              phase_d = PH_HUNT;
            end
          end
          PH_FRAME: begin
            if (count_q == 8'd0) begin
              wr_o.en = 1'b1;
              len_d   = rx_byte_i;
              count_d = 8'd1;
              if (rx_byte_i < MIN_FRAME_LEN || rx_byte_i > 8'(MAX_FRAME_LEN)) begin
                phase_d = PH_HUNT;
              end
            end else if (count_q < len_q) begin
              wr_o.en = 1'b1;
              count_d = count_q + 8'd1;
              if (count_q == 8'd1) begin
                addr_d = rx_byte_i;
              end
            end else if (rx_byte_i == END_DELIM) begin
              phase_d = PH_SYNC;
              if (len_q > MIN_FRAME_LEN) begin
                push_o = 1'b1;
                bank_d = ~bank_q;
              end
            end else begin
              phase_d = PH_HUNT;
            end
          end
          default: begin
            if (rx_byte_i == START_DELIM) begin
              phase_d = PH_FRAME;
              count_d = '0;
            end else if (rx_byte_i == END_DELIM) begin
              phase_d = PH_SYNC;
            end else begin
              phase_d = PH_HUNT;
            end
          end
        endcase
      end
    end
  end

  // bank ownership: set on hand-over, cleared when the drain finishes
  always_comb begin
    busy_d = busy_q;
    if (done_i.en) begin
      busy_d[done_i.bank] = 1'b0;
    end
    if (push_o) begin
      busy_d[bank_q] = 1'b1;
    end
  end

endmodule

`default_nettype wire

>>> src/stxrx_queue.sv
// stxrx_queue: two-entry queue of frame descriptors between front and back
`default_nettype none

module stxrx_queue import stxrx_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  push_i,
  input  wire desc_t din_i,
  input  wire logic  pop_i,
  output logic       empty_o,
  output desc_t      dout_o
);

  desc_t      entry_q [NUM_BANKS];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] fill_q;

  // pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      fill_q   <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      fill_q <= fill_q + {1'b0, push_i} - {1'b0, pop_i};
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= din_i;
    end
  end

  assign empty_o = (fill_q == 2'd0);
  assign dout_o  = entry_q[rd_ptr_q];

endmodule

`default_nettype wire

>>> src/stxrx_back.sv
// stxrx_back: double-banked frame store and payload chunk drain
`default_nettype none

module stxrx_back import stxrx_pkg::*; #(
  parameter int unsigned MAX_FRAME_LEN    = 255,
  parameter int unsigned BYTES_PER_RESULT = 4
) (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire wr_req_t wr_i,
  input  wire logic    q_empty_i,
  input  wire desc_t   q_desc_i,
  output logic         q_pop_o,
  output done_t        done_o,
  output logic         out_valid_o,
  input  wire logic    out_stall_i,
  output logic [7:0]   dest_address_o,
  output logic [31:0]  payload_chunk_o,
  output logic [2:0]   chunk_count_o,
  output logic         last_chunk_o
);

  localparam int unsigned IW = $clog2(MAX_FRAME_LEN);
  localparam int unsigned CW = $clog2(BYTES_PER_RESULT + 1);
  localparam int unsigned DW = 8 * BYTES_PER_RESULT;

  logic [7:0]    mem_q [NUM_BANKS][MAX_FRAME_LEN];
  logic [7:0]    rdata_q;
  logic          rd_en;

  drain_e        state_q, state_d;
  logic          bank_q, bank_d;
  logic [7:0]    addr_q, addr_d;
  logic [7:0]    rem_q, rem_d;
  logic [7:0]    ptr_q, ptr_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [DW-1:0] chunk_q, chunk_d;
  logic          last_q, last_d;

  // frame store: one write port from the front, one registered read port
  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem_q[wr_i.bank][wr_i.idx[IW-1:0]] <= wr_i.data;
    end
    if (rd_en) begin
      rdata_q <= mem_q[bank_q][ptr_q[IW-1:0]];
    end
  end

  // sequencer state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= DR_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // drain datapath registers
  always_ff @(posedge clk_i) begin
    bank_q  <= bank_d;
    addr_q  <= addr_d;
    rem_q   <= rem_d;
    ptr_q   <= ptr_d;
    cnt_q   <= cnt_d;
    chunk_q <= chunk_d;
    last_q  <= last_d;
  end

  // next state: fetch each byte through a read and a wait state, pack, present the chunk
  always_comb begin
    state_d     = state_q;
    bank_d      = bank_q;
    addr_d      = addr_q;
    rem_d       = rem_q;
    ptr_d       = ptr_q;
    cnt_d       = cnt_q;
    chunk_d     = chunk_q;
    last_d      = last_q;
    rd_en       = 1'b0;
    q_pop_o     = 1'b0;
    done_o.en   = 1'b0;
    done_o.bank = bank_q;

    case (state_q)
      DR_IDLE: begin
        if (!q_empty_i) begin
          q_pop_o = 1'b1;
          bank_d  = q_desc_i.bank;
          addr_d  = q_desc_i.addr;
          rem_d   = q_desc_i.plen;
          ptr_d   = 8'd2;
          cnt_d   = '0;
          chunk_d = '0;
          last_d  = 1'b0;
          state_d = DR_READ;
        end
      end
      DR_READ: begin
        rd_en   = 1'b1;
        ptr_d   = ptr_q + 8'd1;
        state_d = DR_WAIT;
      end
      DR_WAIT: begin
        for (int unsigned i = 0; i < BYTES_PER_RESULT; i++) begin
          if (cnt_q == CW'(i)) begin
            chunk_d[i*8 +: 8] = rdata_q;
          end
        end
        cnt_d = cnt_q + CW'(1);
        rem_d = rem_q - 8'd1;
        if (rem_q == 8'd1 || cnt_q == CW'(BYTES_PER_RESULT - 1)) begin
          last_d  = (rem_q == 8'd1);
          state_d = DR_OUT;
        end else begin
          state_d = DR_READ;
        end
      end
      DR_OUT: begin
        if (!out_stall_i) begin
          if (last_q) begin
            done_o.en = 1'b1;
            state_d   = DR_IDLE;
          end else begin
            cnt_d   = '0;
            chunk_d = '0;
            state_d = DR_READ;
          end
        end
      end
      default: begin
        state_d = DR_IDLE;
      end
    endcase
  end

  // result outputs straight from registers
  assign out_valid_o     = (state_q == DR_OUT);
  assign dest_address_o  = addr_q;
  assign payload_chunk_o = 32'(chunk_q);
  assign chunk_count_o   = 3'(cnt_q);
  assign last_chunk_o    = last_q;

endmodule

`default_nettype wire

>>> src/stx_length_etx_frame_receiver_top.sv
// stx_length_etx_frame_receiver_top: STX / length / ETX frame receiver top level
//
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+--------------------------------------
//  in      | input     | in_valid_i/in_stall_o | op_i, rx_byte_i
//  out     | output    | out_valid_o/out_stall_i| dest_address_o, payload_chunk_o,
//          |           |                       | chunk_count_o, last_chunk_o
//
// an input byte is taken in the cycle it is offered; a frame byte is held off only
// while the next frame's store bank is still being drained from an earlier frame.
// each result fetches its payload bytes one per store read, each through a read
// and a wait state, then holds the chunk until taken; a drain opens with a queue pop.
// two store banks let one frame be received while the previous one drains.
// reset is asynchronous and active low; it clears phase, counters and bank use.
`default_nettype none

module stx_length_etx_frame_receiver_top import stxrx_pkg::*; #(
  parameter int unsigned MAX_FRAME_LEN    = 255,
  parameter int unsigned BYTES_PER_RESULT = 4
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic        op_i,
  input  wire logic [7:0]  rx_byte_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [7:0]       dest_address_o,
  output logic [31:0]      payload_chunk_o,
  output logic [2:0]       chunk_count_o,
  output logic             last_chunk_o
);

  wr_req_t wr;
  logic    push;
  desc_t   desc_in;
  logic    pop;
  logic    q_empty;
  desc_t   desc_out;
  done_t   done;

  // byte parser and store writer
  stxrx_front #(
    .MAX_FRAME_LEN(MAX_FRAME_LEN)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .op_i       (op_i),
    .rx_byte_i  (rx_byte_i),
    .wr_o       (wr),
    .push_o     (push),
    .desc_o     (desc_in),
    .done_i     (done)
  );

  // accepted frames waiting for the drain
  stxrx_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .din_i   (desc_in),
    .pop_i   (pop),
    .empty_o (q_empty),
    .dout_o  (desc_out)
  );

  // frame store and chunk output
  stxrx_back #(
    .MAX_FRAME_LEN   (MAX_FRAME_LEN),
    .BYTES_PER_RESULT(BYTES_PER_RESULT)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .wr_i            (wr),
    .q_empty_i       (q_empty),
    .q_desc_i        (desc_out),
    .q_pop_o         (pop),
    .done_o          (done),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .dest_address_o  (dest_address_o),
    .payload_chunk_o (payload_chunk_o),
    .chunk_count_o   (chunk_count_o),
    .last_chunk_o    (last_chunk_o)
  );

endmodule

`default_nettype wire
